/* rtl/core/zoke_pkg.sv */
// Package: shared widths and defaults for the 0-1 knapsack engine.
package zoke_pkg;
	localparam int MAX_CAPACITY_DEF = 1023;
	localparam int CAP_W            = 10;
	localparam int WEIGHT_W         = 10;
	localparam int VALUE_W          = 16;
	localparam int RESULT_W         = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;
endpackage

/* rtl/core/zero_one_knapsack_engine_unit.sv */
// Top level: 0-1 knapsack engine, one table entry updated per cycle.
// An item of weight w within capacity cap visits entries cap down to w, then drains;
// a heavier non-last item leaves busy low. A last item adds a table read and a result
// load; done is high for a single cycle with best_value, in the first clearing cycle.
// After reset and each answer a clearing pass zeroes entries 0..MAX_CAPACITY with busy high.
// Reset is asynchronous, active low; capacity resets to 1023. The receiver cannot stall.
module zero_one_knapsack_engine_unit #(
	parameter int MAX_CAPACITY = zoke_pkg::MAX_CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [zoke_pkg::WEIGHT_W-1:0] item_weight,
	input  logic [zoke_pkg::VALUE_W-1:0]  item_value,
	input  logic                          last_item,
	input  logic                          cfg_we,
	input  logic [zoke_pkg::CAP_W-1:0]    cfg_wdata,
	output logic                          done,
	output logic [zoke_pkg::RESULT_W-1:0] best_value
);
	import zoke_pkg::*;

	localparam int DEPTH = MAX_CAPACITY + 1;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_UPDATE = 6'b000010,
		ST_DRAIN  = 6'b000100,
		ST_READ   = 6'b001000,
		ST_EMIT   = 6'b010000,
		ST_CLEAR  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [AW-1:0]       cap_q;
	logic [AW-1:0]       c_q;
	logic [AW-1:0]       w_q;
	logic [VALUE_W-1:0]  val_q;
	logic                last_q;
	logic [AW-1:0]       clr_q;
	logic                vld_s1;
	logic [AW-1:0]       waddr_s1;
	logic                done_q;
	logic [RESULT_W-1:0] best_value_q;

	logic [AW-1:0]       cap_eff;
	logic                fits;
	logic [AW-1:0]       ra_a;
	logic [AW-1:0]       ra_b;
	logic [RESULT_W-1:0] rd_a;
	logic [RESULT_W-1:0] rd_b;
	logic [RESULT_W:0]   sum;
	logic [RESULT_W-1:0] with_item;
	logic                ram_we;
	logic [AW-1:0]       ram_wa;
	logic [RESULT_W-1:0] ram_wd;

	assign cap_eff = (32'(capacity_q) > 32'(MAX_CAPACITY)) ? AW'(MAX_CAPACITY)
	                                                       : AW'(capacity_q);
	assign fits    = 32'(item_weight) <= 32'(cap_eff);

	assign sum       = {1'b0, rd_b} + (RESULT_W+1)'(val_q);
	assign with_item = sum[RESULT_W] ? '1 : sum[RESULT_W-1:0];

	always_comb begin
		ra_a = c_q;
		ra_b = c_q - w_q;
		if (state_q == ST_READ) begin
			ra_a = cap_q;
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_wa = clr_q;
			ram_wd = '0;
		end else begin
			ram_we = vld_s1 && (with_item > rd_a);
			ram_wa = waddr_s1;
			ram_wd = with_item;
		end
	end

	zoke_ram #(
		.WIDTH(RESULT_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_wa),
		.wdata  (ram_wd),
		.raddr_a(ra_a),
		.raddr_b(ra_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_UPDATE);
			done_q <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (fits) begin
							state_q <= ST_UPDATE;
						end else if (last_item) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_UPDATE: begin
					if (c_q == w_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= last_q ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					clr_q   <= '0;
					state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (clr_q == AW'(MAX_CAPACITY)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cap_q  <= cap_eff;
			c_q    <= cap_eff;
			w_q    <= AW'(item_weight);
			val_q  <= item_value;
			last_q <= last_item;
		end else if (state_q == ST_UPDATE && c_q != w_q) begin
			c_q <= c_q - 1'b1;
		end
		waddr_s1 <= c_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_value_q <= '0;
		end else if (state_q == ST_EMIT) begin
			best_value_q <= rd_a;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign best_value = best_value_q;
endmodule

/* rtl/core/zoke_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
module zoke_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

/* rtl/core/zoke_checker.sv */
// Checker: port-level properties of the knapsack engine, bound to the top level.
module zoke_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          last_item,
	input logic                          done,
	input logic [zoke_pkg::RESULT_W-1:0] best_value
);
	import zoke_pkg::*;

	a_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result transaction without the following clearing pass");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result transaction repeated");

	a_no_result_non_last: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_item) |=> !done)
		else $error("result transaction after a non-last item");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(best_value) |-> done)
		else $error("best_value changed without a result transaction");
endmodule

bind zero_one_knapsack_engine_unit zoke_checker u_zoke_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.last_item (last_item),
	.done      (done),
	.best_value(best_value)
);

/* dv/zoke_tb_pkg.sv */
// Scoreboard for the knapsack engine: table predictor and pending answer queue.
package zoke_tb_pkg;
	import zoke_pkg::*;

	class knapsack_checker;
		logic [RESULT_W-1:0] best_tbl [0:MAX_CAPACITY_DEF];
		logic [CAP_W-1:0]    cap;
		logic [RESULT_W-1:0] answers [$];
		int                  errors;

		function new();
			clear_table();
			cap = CAP_RESET;
			errors = 0;
		endfunction

		function void clear_table();
			foreach (best_tbl[i]) best_tbl[i] = '0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			cap = c;
		endfunction

		function void note_item(logic [WEIGHT_W-1:0] w, logic [VALUE_W-1:0] v, logic last);
			int             wt;
			int             top;
			logic [RESULT_W:0] sum;
			wt = w;
			top = cap;
			if (top > MAX_CAPACITY_DEF) top = MAX_CAPACITY_DEF;
			if (wt <= top) begin
				for (int c = top; c >= wt; c--) begin
					sum = best_tbl[c-wt] + v;
					if (sum[RESULT_W]) sum[RESULT_W-1:0] = '1;
					if (sum[RESULT_W-1:0] > best_tbl[c]) best_tbl[c] = sum[RESULT_W-1:0];
				end
			end
			if (last) begin
				answers.push_back(best_tbl[top]);
				clear_table();
			end
		endfunction

		function void check_answer(logic [RESULT_W-1:0] got);
			logic [RESULT_W-1:0] want;
			if (answers.size() == 0) begin
				flag($sformatf("best_value %0d with no answer pending", got));
				return;
			end
			want = answers.pop_front();
			if (got !== want)
				flag($sformatf("best_value mismatch: expected %0d, got %0d", want, got));
		endfunction

		function void flush_missing();
			while (answers.size() != 0)
				flag($sformatf("best_value %0d never returned", answers.pop_front()));
		endfunction
	endclass
endpackage

/* dv/tb_zero_one_knapsack_engine_unit.sv */
// Testbench top: drives knapsack problems into the engine and checks every answer.
module tb_zero_one_knapsack_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import zoke_pkg::*;
	import zoke_tb_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [WEIGHT_W-1:0] item_weight;
	logic [VALUE_W-1:0]  item_value;
	logic                last_item;
	logic                cfg_we;
	logic [CAP_W-1:0]    cfg_wdata;
	logic                done;
	logic [RESULT_W-1:0] best_value;

	knapsack_checker kc;
	int              gap_pct;

	zero_one_knapsack_engine_unit #(
		.MAX_CAPACITY(MAX_CAPACITY_DEF)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item_weight(item_weight),
		.item_value (item_value),
		.last_item  (last_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.best_value (best_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) kc.note_item(item_weight, item_value, last_item);
			if (done) kc.check_answer(best_value);
		end
	end

	task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
			input logic l);
		int n;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			n = ($urandom_range(3) == 0) ? $urandom_range(60, 12) : $urandom_range(6, 1);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		start       <= 1'b1;
		item_weight <= w;
		item_value  <= v;
		last_item   <= l;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		int n;
		start <= 1'b0;
		while (kc.answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		n = 0;
		while (busy && n < 3000) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		kc.set_capacity(c);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int                  cap;
		int                  left;
		int                  nitems;
		logic                lst;
		logic [WEIGHT_W-1:0] w;
		logic [VALUE_W-1:0]  v;

		kc = new();
		gap_pct     = 0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		item_weight <= '0;
		item_value  <= '0;
		last_item   <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// reset capacity
		send_item(10'd1023, 16'hFFFF, 1'b0);
		send_item(10'd0, 16'd0, 1'b0);
		send_item(10'd512, 16'd1000, 1'b0);
		send_item(10'd511, 16'd7, 1'b1);
		wait_idle();

		write_capacity(10'd10);
		send_item(10'd11, 16'd500, 1'b1);
		send_item(10'd3, 16'd40, 1'b0);
		send_item(10'd4, 16'd50, 1'b0);
		send_item(10'd5, 16'd65, 1'b0);
		send_item(10'd0, 16'd9, 1'b1);
		wait_idle();

		// change capacity within one problem
		send_item(10'd6, 16'd100, 1'b0);
		wait_idle();
		write_capacity(10'd4);
		send_item(10'd4, 16'd30, 1'b0);
		wait_idle();
		write_capacity(10'd12);
		send_item(10'd6, 16'd90, 1'b1);
		wait_idle();

		write_capacity(10'd0);
		send_item(10'd0, 16'hFFFF, 1'b0);
		send_item(10'd1, 16'd5, 1'b0);
		send_item(10'd0, 16'd1, 1'b1);
		wait_idle();

		write_capacity(10'd1);
		send_item(10'd1, 16'hFFFF, 1'b0);
		send_item(10'd1, 16'hFFFF, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: cap = 1023;
				1: cap = 0;
				2: cap = 1;
				4: cap = $urandom_range(255, 41);
				6: cap = 700;
				default: cap = $urandom_range(40, 2);
			endcase
			gap_pct = (ph % 3 == 1) ? 78 : (ph % 3 == 2) ? 16 : 0;
			write_capacity(cap[CAP_W-1:0]);
			nitems = (cap > 255) ? 24 : 84;
			left = 0;
			for (int k = 0; k < nitems; k++) begin
				if (left == 0)
					left = ($urandom_range(4) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
				left--;
				case ($urandom_range(9))
					0: w = WEIGHT_W'($urandom_range(1023));
					1: w = (cap < 1023) ? WEIGHT_W'($urandom_range(1023, cap + 1)) : 10'd1023;
					default: w = WEIGHT_W'($urandom_range(cap));
				endcase
				case ($urandom_range(9))
					0: v = '0;
					1: v = '1;
					2: v = VALUE_W'($urandom_range(15));
					default: v = VALUE_W'($urandom_range(65535));
				endcase
				lst = (left == 0) || (k == nitems - 1);
				if (lst) left = 0;
				send_item(w, v, lst);
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		kc.flush_missing();
		if (kc.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
